// File: rtl/esu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence unescaper package
// Shared result codes, the run descriptor passed from the decoder to the
// emitter, and the escape and UTF-8 encoding functions.
// ----------------------------------------------------------------------------
package esu_pkg;

  // Result kinds carried on the output channel.
  localparam logic [1:0] KIND_DATA        = 2'd0;
  localparam logic [1:0] KIND_DONE        = 2'd1;
  localparam logic [1:0] KIND_BAD_ESCAPE  = 2'd2;
  localparam logic [1:0] KIND_BAD_UNICODE = 2'd3;

  // Default depth of the run queue between the decoder and the emitter.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Up to four data bytes, first byte in slot 0.
  typedef struct packed {
    logic             ok;
    logic [2:0]       cnt;
    logic [3:0][7:0]  data;
  } esu_bytes_t;

  // Everything one input word produces: data bytes, then an optional
  // status result (done or an error).
  typedef struct packed {
    logic [2:0]       data_cnt;
    logic [3:0][7:0]  data;
    logic             has_tail;
    logic [1:0]       tail_kind;
  } esu_run_t;

  // Hex digit value; bit 4 is set when the character is a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Single-character escapes. ok is clear for an unknown escape; the hex
  // escapes are handled by the caller.
  function automatic esu_bytes_t escape_map(input logic [7:0] c);
    esu_bytes_t r;
    r = '0;
    r.ok  = 1'b1;
    r.cnt = 3'd1;
    case (c)
      8'h22, 8'h27, 8'h2F, 8'h20, 8'h5C: r.data[0] = c;
      8'h30: r.data[0] = 8'h00;
      8'h61: r.data[0] = 8'h07;
      8'h62: r.data[0] = 8'h08;
      8'h74: r.data[0] = 8'h09;
      8'h6E: r.data[0] = 8'h0A;
      8'h76: r.data[0] = 8'h0B;
      8'h72: r.data[0] = 8'h0D;
      8'h65: r.data[0] = 8'h1B;
      8'h5F: begin
        r.cnt = 3'd2; r.data[0] = 8'hC2; r.data[1] = 8'hA0;
      end
      8'h4E: begin
        r.cnt = 3'd2; r.data[0] = 8'hC2; r.data[1] = 8'h85;
      end
      8'h4C: begin
        r.cnt = 3'd3; r.data[0] = 8'hE2; r.data[1] = 8'h80; r.data[2] = 8'hA8;
      end
      8'h50: begin
        r.cnt = 3'd3; r.data[0] = 8'hE2; r.data[1] = 8'h80; r.data[2] = 8'hA9;
      end
      default: begin
        r.ok  = 1'b0;
        r.cnt = 3'd0;
      end
    endcase
    return r;
  endfunction

  // UTF-8 encoding of a code point. ok is clear for surrogates, the two
  // noncharacters FFFE and FFFF, and anything beyond the Unicode range.
  function automatic esu_bytes_t utf8_encode(input logic [31:0] cp);
    esu_bytes_t r;
    r = '0;
    r.ok = 1'b1;
    if ((cp >= 32'h0000_D800 && cp <= 32'h0000_DFFF) ||
        cp == 32'h0000_FFFE || cp == 32'h0000_FFFF || cp >= 32'h0011_0000) begin
      r.ok = 1'b0;
    end else if (cp < 32'h0000_0080) begin
      r.cnt = 3'd1;
      r.data[0] = cp[7:0];
    end else if (cp < 32'h0000_0800) begin
      r.cnt = 3'd2;
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
    end else if (cp < 32'h0001_0000) begin
      r.cnt = 3'd3;
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt = 3'd4;
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/esu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence unescaper channels
// Valid/ready channels for raw lexeme bytes and for unescaped results.
// ----------------------------------------------------------------------------
interface esu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_lexeme;

  modport source (output valid, in_byte, end_of_lexeme, input ready);
  modport sink   (input valid, in_byte, end_of_lexeme, output ready);
endinterface

interface esu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last_of_run;

  modport source (output valid, out_byte, kind, last_of_run, input ready);
  modport sink   (input valid, out_byte, kind, last_of_run, output ready);
endinterface

// File: rtl/esu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Accepts one lexeme word per cycle while the queue has room, tracks the
// escape state and turns each word into a run descriptor for the emitter.
// ----------------------------------------------------------------------------
module esu_front (
  input  logic               clk,
  input  logic               rst_n,
  esu_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               push,
  output esu_pkg::esu_run_t  run
);

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_ESCAPE  = 2'd1;
  localparam logic [1:0] MODE_HEX     = 2'd2;
  localparam logic [1:0] MODE_DISCARD = 2'd3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U_LOW  = 8'h75;
  localparam logic [7:0] CH_U_UP   = 8'h55;

  logic [1:0]  mode_r, mode_nxt;
  logic [3:0]  hex_left_r, hex_left_nxt;
  logic [31:0] acc_r, acc_nxt;

  logic                 fire;
  logic [7:0]           c;
  logic                 last;
  logic                 err;
  logic [1:0]           err_kind;
  logic [4:0]           hv;
  logic [3:0]           hl_dec;
  esu_pkg::esu_bytes_t  esc;
  esu_pkg::esu_bytes_t  enc;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;
  assign last        = in_ch.end_of_lexeme;
  assign hv          = esu_pkg::hex_value(c);
  assign hl_dec      = hex_left_r - 4'd1;
  assign esc         = esu_pkg::escape_map(c);
  assign enc         = esu_pkg::utf8_encode({acc_r[27:0], hv[3:0]});

  always_comb begin
    mode_nxt     = mode_r;
    hex_left_nxt = hex_left_r;
    acc_nxt      = acc_r;
    run          = '0;
    err          = 1'b0;
    err_kind     = esu_pkg::KIND_BAD_ESCAPE;
    case (mode_r)
      MODE_NORMAL: begin
        if (c == CH_BSLASH) begin
          if (last) begin
            err = 1'b1;
          end else begin
            mode_nxt = MODE_ESCAPE;
          end
        end else begin
          run.data_cnt = 3'd1;
          run.data[0]  = c;
        end
      end
      MODE_ESCAPE: begin
        mode_nxt = MODE_NORMAL;
        if (c == CH_X || c == CH_U_LOW || c == CH_U_UP) begin
          hex_left_nxt = (c == CH_X) ? 4'd2 : (c == CH_U_LOW) ? 4'd4 : 4'd8;
          acc_nxt      = '0;
          if (last) begin
            err = 1'b1;
          end else begin
            mode_nxt = MODE_HEX;
          end
        end else if (esc.ok) begin
          run.data_cnt = esc.cnt;
          run.data     = esc.data;
        end else begin
          err = 1'b1;
        end
      end
      MODE_HEX: begin
        if (!hv[4]) begin
          err = 1'b1;
        end else begin
          acc_nxt      = {acc_r[27:0], hv[3:0]};
          hex_left_nxt = hl_dec;
          if (hl_dec != 4'd0) begin
            err = last;
          end else begin
            mode_nxt = MODE_NORMAL;
            if (enc.ok) begin
              run.data_cnt = enc.cnt;
              run.data     = enc.data;
            end else begin
              err      = 1'b1;
              err_kind = esu_pkg::KIND_BAD_UNICODE;
            end
          end
        end
      end
      default: begin
        if (last) begin
          mode_nxt = MODE_NORMAL;
        end
      end
    endcase

    if (mode_r != MODE_DISCARD) begin
      if (err) begin
        run.data_cnt  = 3'd0;
        run.has_tail  = 1'b1;
        run.tail_kind = err_kind;
        mode_nxt      = last ? MODE_NORMAL : MODE_DISCARD;
        hex_left_nxt  = 4'd0;
      end else if (last) begin
        run.has_tail  = 1'b1;
        run.tail_kind = esu_pkg::KIND_DONE;
        mode_nxt      = MODE_NORMAL;
        hex_left_nxt  = 4'd0;
      end
    end
  end

  assign push = fire && (run.data_cnt != 3'd0 || run.has_tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      hex_left_r <= 4'd0;
      acc_r      <= '0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      hex_left_r <= hex_left_nxt;
      acc_r      <= acc_nxt;
    end
  end

  // An error result always stands alone.
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    push && run.has_tail && run.tail_kind != esu_pkg::KIND_DONE |-> run.data_cnt == 3'd0)
    else $error("error run carries data bytes");

endmodule

// File: rtl/esu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run queue
// Short first-in first-out buffer of run descriptors between the decoder
// and the emitter.
// ----------------------------------------------------------------------------
module esu_queue #(
  parameter int DEPTH = esu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  esu_pkg::esu_run_t  wr_run,
  input  logic               pop,
  output esu_pkg::esu_run_t  rd_run,
  output logic               full,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  esu_pkg::esu_run_t slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign rd_run = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full run queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from empty run queue");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CW'(1))
    else $error("run queue count did not follow a push");

endmodule

// File: rtl/esu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result emitter
// Takes run descriptors from the queue and presents their results one word
// per cycle on the output channel while it is ready.
// ----------------------------------------------------------------------------
module esu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  esu_pkg::esu_run_t  q_run,
  input  logic               q_empty,
  output logic               pop,
  esu_out_if.source          out_ch
);

  esu_pkg::esu_run_t cur_r;
  logic              busy_r;
  logic [2:0]        idx_r;

  logic [2:0] total;
  logic       is_data;
  logic       is_last;
  logic       fire;
  logic       take;

  assign total   = cur_r.data_cnt + {2'b00, cur_r.has_tail};
  assign is_data = (idx_r < cur_r.data_cnt);
  assign is_last = (idx_r == total - 3'd1);
  assign fire    = out_ch.valid && out_ch.ready;
  assign take    = !busy_r || (fire && is_last);
  assign pop     = take && !q_empty;

  assign out_ch.valid       = busy_r;
  assign out_ch.out_byte    = is_data ? cur_r.data[idx_r[1:0]] : 8'h00;
  assign out_ch.kind        = is_data ? esu_pkg::KIND_DATA : cur_r.tail_kind;
  assign out_ch.last_of_run = is_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (take) begin
      busy_r <= !q_empty;
      idx_r  <= 3'd0;
    end else if (fire) begin
      idx_r  <= idx_r + 3'd1;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_ch.ready |=> busy_r && $stable(idx_r))
    else $error("emitter advanced while stalled");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r < total)
    else $error("emitter index past end of run");

endmodule

// File: rtl/escape_sequence_unescaper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence unescaper
// Decodes double-quoted lexeme escapes into UTF-8 bytes with status results.
// ----------------------------------------------------------------------------
// The block takes one raw lexeme byte per cycle on in_ch and returns the
// unescaped bytes on out_ch, one result word per cycle, followed on the final
// byte of a lexeme by a done word, or by a single error word (bad escape or
// bad code point) after which the rest of that lexeme is dropped. A decoder
// accepts a byte every cycle and UTF-8 encodes a completed hex escape in the
// same cycle; each byte produces zero to five result words. An emitter drains
// them at one word per cycle while out_ch is ready, so a byte that yields k
// results holds the emitter until all k are out, and a queue of QUEUE_DEPTH
// run entries between the two absorbs bursts. Input back-pressure appears
// only when that queue is full, i.e. when the result stream has been stalled
// or has produced more words than bytes over a stretch of time.
// There is no configuration and no clearing pass after reset.
// ----------------------------------------------------------------------------
module escape_sequence_unescaper_top #(
  parameter int QUEUE_DEPTH = esu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  esu_in_if.sink     in_ch,
  esu_out_if.source  out_ch
);

  // Run descriptors from the decoder to the queue and from the queue to
  // the emitter.
  esu_pkg::esu_run_t wr_run;
  esu_pkg::esu_run_t rd_run;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;

  // Front end: escape state machine and hex accumulation; ready follows
  // only the queue's fill level.
  esu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .run    (wr_run)
  );

  // Decoupling queue, one entry per input byte that has results.
  esu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_run (wr_run),
    .pop    (pop),
    .rd_run (rd_run),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Back end: serializes each run into result words, marking the last
  // word of every run.
  esu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_run   (rd_run),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
